[sv/slx_pkg.sv]
// ----------------------------------------------------------------------------
// slx_pkg - shared types and helpers for the source text lexer
// Token kinds, lexer state, character classes and keyword lookup.
// ----------------------------------------------------------------------------
package slx_pkg;

	// Token queue geometry
	localparam int TokqDepth = 4;
	localparam int PtrW      = $clog2(TokqDepth);
	localparam int CntW      = $clog2(TokqDepth + 1);

	// Character constants
	localparam logic [7:0] ChHash  = 8'h23;
	localparam logic [7:0] ChEq    = 8'h3D;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChLowF  = 8'h66;
	localparam logic [7:0] ChLowN  = 8'h6E;
	localparam logic [7:0] ChLowI  = 8'h69;
	localparam logic [7:0] ChLowR  = 8'h72;
	localparam logic [7:0] ChLowE  = 8'h65;
	localparam logic [7:0] ChLowT  = 8'h74;
	localparam logic [7:0] ChLowV  = 8'h76;
	localparam logic [7:0] ChLowA  = 8'h61;

	typedef enum logic [4:0] {
		KIND_EOF    = 5'd0,
		KIND_SEMI   = 5'd1,
		KIND_COMMA  = 5'd2,
		KIND_LBRACE = 5'd3,
		KIND_RBRACE = 5'd4,
		KIND_LPAREN = 5'd5,
		KIND_RPAREN = 5'd6,
		KIND_FN     = 5'd7,
		KIND_RET    = 5'd8,
		KIND_VAR    = 5'd9,
		KIND_COLON  = 5'd10,
		KIND_ASSIGN = 5'd11,
		KIND_EQUAL  = 5'd12,
		KIND_MUL    = 5'd13,
		KIND_DIV    = 5'd14,
		KIND_ADD    = 5'd15,
		KIND_SUB    = 5'd16,
		KIND_IF     = 5'd17,
		KIND_IDENT  = 5'd18,
		KIND_INT    = 5'd19,
		KIND_ERROR  = 5'd20
	} token_kind_t;

	typedef enum logic [5:0] {
		M_IDLE    = 6'b000001,
		M_IDENT   = 6'b000010,
		M_NUM     = 6'b000100,
		M_COMMENT = 6'b001000,
		M_EQ      = 6'b010000,
		M_HALT    = 6'b100000
	} lex_mode_t;

	typedef struct packed {
		token_kind_t kind;
		logic [31:0] value;
		logic [31:0] start;
		logic [15:0] len;
		logic [7:0]  bad;
		logic        last;
	} token_t;

	typedef struct packed {
		lex_mode_t       mode;
		logic [2:0][7:0] first_chars;
		logic [15:0]     run_len;
		logic [31:0]     accum;
		logic [31:0]     pos;
		logic [31:0]     start;
	} lex_state_t;

	// Results of one step: count, then tokens in delivery order
	typedef struct packed {
		logic [1:0]        n;
		logic [1:0][$bits(token_t)-1:0] tok;
	} step_res_t;

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// Single-character punctuation, error for anything unknown
	function automatic token_kind_t punct_kind(logic [7:0] c);
		token_kind_t k;
		case (c)
			8'h3B:   k = KIND_SEMI;
			8'h2C:   k = KIND_COMMA;
			8'h7B:   k = KIND_LBRACE;
			8'h7D:   k = KIND_RBRACE;
			8'h28:   k = KIND_LPAREN;
			8'h29:   k = KIND_RPAREN;
			8'h3A:   k = KIND_COLON;
			8'h2A:   k = KIND_MUL;
			8'h2F:   k = KIND_DIV;
			8'h2B:   k = KIND_ADD;
			8'h2D:   k = KIND_SUB;
			default: k = KIND_ERROR;
		endcase
		return k;
	endfunction

	// Keyword match from the first three characters and the length
	function automatic token_kind_t kw_kind(logic [2:0][7:0] fc, logic [15:0] len);
		token_kind_t k;
		k = KIND_IDENT;
		if (len == 16'd2 && fc[0] == ChLowF && fc[1] == ChLowN)
			k = KIND_FN;
		else if (len == 16'd2 && fc[0] == ChLowI && fc[1] == ChLowF)
			k = KIND_IF;
		else if (len == 16'd3 && fc[0] == ChLowR && fc[1] == ChLowE && fc[2] == ChLowT)
			k = KIND_RET;
		else if (len == 16'd3 && fc[0] == ChLowV && fc[1] == ChLowA && fc[2] == ChLowR)
			k = KIND_VAR;
		return k;
	endfunction

endpackage

[sv/slx_step.sv]
// ----------------------------------------------------------------------------
// slx_step - one lexer step
// Combinational next state and up to two tokens for one source byte.
// ----------------------------------------------------------------------------
module slx_step (
	input  slx_pkg::lex_state_t st,
	input  logic [7:0]          ch,
	input  logic                eof,
	output slx_pkg::lex_state_t nxt,
	output slx_pkg::step_res_t  res
);

	slx_pkg::token_t close_tok;
	slx_pkg::token_t idle_tok;
	logic            close_p;
	logic            idle_p;
	logic            do_idle;
	logic            alnum;
	logic [15:0]     len_inc;
	logic [31:0]     accum_x10;
	slx_pkg::token_kind_t pk;

	assign alnum     = slx_pkg::is_alpha(ch) || slx_pkg::is_digit(ch);
	assign len_inc   = (st.run_len == 16'hFFFF) ? st.run_len : st.run_len + 16'd1;
	assign accum_x10 = {st.accum[28:0], 3'b000} + {st.accum[30:0], 1'b0};
	assign pk        = slx_pkg::punct_kind(ch);

	// Pending token handling by mode
	always_comb begin
		nxt       = st;
		close_p   = 1'b0;
		close_tok = '0;
		do_idle   = 1'b0;
		unique case (st.mode)
			slx_pkg::M_IDENT: begin
				if (!eof && alnum) begin
					if (st.run_len < 16'd3)
						nxt.first_chars[st.run_len[1:0]] = ch;
					nxt.run_len = len_inc;
				end else begin
					close_p        = 1'b1;
					close_tok.kind = slx_pkg::kw_kind(st.first_chars, st.run_len);
					close_tok.start = st.start;
					close_tok.len  = st.run_len;
					do_idle        = 1'b1;
				end
			end
			slx_pkg::M_NUM: begin
				if (!eof && slx_pkg::is_digit(ch)) begin
					nxt.accum   = accum_x10 + {24'd0, ch - slx_pkg::ChZero};
					nxt.run_len = len_inc;
				end else begin
					close_p         = 1'b1;
					close_tok.kind  = slx_pkg::KIND_INT;
					close_tok.value = st.accum;
					close_tok.start = st.start;
					close_tok.len   = st.run_len;
					do_idle         = 1'b1;
				end
			end
			slx_pkg::M_COMMENT: begin
				if (eof)
					do_idle = 1'b1;
				else if (ch == slx_pkg::ChLf || ch == slx_pkg::ChCr)
					nxt.mode = slx_pkg::M_IDLE;
			end
			slx_pkg::M_EQ: begin
				close_p         = 1'b1;
				close_tok.start = st.start;
				if (!eof && ch == slx_pkg::ChEq) begin
					close_tok.kind = slx_pkg::KIND_EQUAL;
					close_tok.len  = 16'd2;
					nxt.mode       = slx_pkg::M_IDLE;
				end else begin
					close_tok.kind = slx_pkg::KIND_ASSIGN;
					close_tok.len  = 16'd1;
					do_idle        = 1'b1;
				end
			end
			slx_pkg::M_IDLE: do_idle = 1'b1;
			slx_pkg::M_HALT: ;
			default: ;
		endcase

		// Start a new token or emit a single-byte one
		idle_p   = 1'b0;
		idle_tok = '0;
		if (do_idle) begin
			nxt.mode       = slx_pkg::M_IDLE;
			idle_tok.start = st.pos;
			if (eof) begin
				idle_p        = 1'b1;
				idle_tok.kind = slx_pkg::KIND_EOF;
			end else if (slx_pkg::is_space(ch)) begin
				idle_p = 1'b0;
			end else if (slx_pkg::is_alpha(ch)) begin
				nxt.mode        = slx_pkg::M_IDENT;
				nxt.first_chars = {8'h00, 8'h00, ch};
				nxt.run_len     = 16'd1;
				nxt.start       = st.pos;
			end else if (slx_pkg::is_digit(ch)) begin
				nxt.mode    = slx_pkg::M_NUM;
				nxt.accum   = {24'd0, ch - slx_pkg::ChZero};
				nxt.run_len = 16'd1;
				nxt.start   = st.pos;
			end else if (ch == slx_pkg::ChHash) begin
				nxt.mode = slx_pkg::M_COMMENT;
			end else if (ch == slx_pkg::ChEq) begin
				nxt.mode  = slx_pkg::M_EQ;
				nxt.start = st.pos;
			end else begin
				idle_p        = 1'b1;
				idle_tok.kind = pk;
				idle_tok.len  = 16'd1;
				if (pk == slx_pkg::KIND_ERROR) begin
					idle_tok.bad = ch;
					nxt.mode     = slx_pkg::M_HALT;
				end
			end
		end

		// Advance the stream offset on every byte while running
		if (!eof && st.mode != slx_pkg::M_HALT)
			nxt.pos = st.pos + 32'd1;
	end

	// Pack tokens in order and mark the final one
	always_comb begin
		slx_pkg::token_t t0;
		slx_pkg::token_t t1;
		t0      = close_p ? close_tok : idle_tok;
		t1      = idle_tok;
		t0.last = !(close_p && idle_p);
		t1.last = 1'b1;
		res.n   = {1'b0, close_p} + {1'b0, idle_p};
		res.tok = {t1, t0};
	end

endmodule

[sv/slx_tokq.sv]
// ----------------------------------------------------------------------------
// slx_tokq - token result queue
// Takes up to two tokens per cycle while it has room and delivers one per cycle on each pop.
// ----------------------------------------------------------------------------
module slx_tokq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [1:0]                push_n,
	input  slx_pkg::step_res_t        push_res,
	input  logic                      pop,
	output logic                      room,
	output logic                      not_empty,
	output slx_pkg::token_t           head_tok
);

	slx_pkg::token_t                    slot_q [slx_pkg::TokqDepth];
	logic [slx_pkg::PtrW-1:0]           head_q;
	logic [slx_pkg::PtrW-1:0]           tail_q;
	logic [slx_pkg::CntW-1:0]           count_q;

	assign room      = count_q <= slx_pkg::CntW'(slx_pkg::TokqDepth - 2);
	assign not_empty = count_q != '0;
	assign head_tok  = slot_q[head_q];

	// Write incoming tokens at the tail
	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			slot_q[tail_q] <= slx_pkg::token_t'(push_res.tok[0]);
		if (push_n == 2'd2)
			slot_q[tail_q + slx_pkg::PtrW'(1)] <= slx_pkg::token_t'(push_res.tok[1]);
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + slx_pkg::PtrW'(push_n);
			if (pop)
				head_q <= head_q + slx_pkg::PtrW'(1);
			count_q <= count_q + slx_pkg::CntW'(push_n) - slx_pkg::CntW'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= slx_pkg::CntW'(slx_pkg::TokqDepth))
		else $error("token queue occupancy above depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room && push_n != 2'd3)
		else $error("token queue push without room");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("token queue pop while empty");

endmodule

[sv/source_text_lexer.sv]
// ----------------------------------------------------------------------------
// source_text_lexer - byte-stream tokenizer with keywords
// One source byte per item in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   src channel carries ch and end_of_input; an item is taken when src_valid
//   is high and src_stall is low. tok channel carries one token per item with
//   last marking the final token caused by a source item.
//   A byte is registered on arrival and lexed once the queue has room; its
//   tokens land in a four-entry queue, whose head shows the first token.
//   Throughput is one byte per cycle while src_stall is low; the single
//   output port of the token queue sets the sustained rate at one token per
//   cycle while tok_stall is low, so a byte with two tokens uses two slots.
//   When tok_stall is held the queue fills and src_stall rises once fewer
//   than two queue entries are free; nothing is dropped.
//   Reset clears the lexer to idle at stream offset zero and empties the
//   queue. After an error token the lexer drops every byte until reset.
// ----------------------------------------------------------------------------
module source_text_lexer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  logic [7:0]         ch,
	input  logic               end_of_input,
	output logic               tok_valid,
	input  logic               tok_stall,
	output logic [4:0]         token_kind,
	output logic signed [31:0] int_value,
	output logic [31:0]        token_start,
	output logic [15:0]        token_length,
	output logic [7:0]         bad_char,
	output logic               last
);

	logic                valid_s1;
	logic [7:0]          ch_s1;
	logic                eof_s1;
	slx_pkg::lex_state_t state_q;
	slx_pkg::lex_state_t state_nxt;
	slx_pkg::step_res_t  res;
	slx_pkg::token_t     head_tok;
	logic                room;
	logic                adv;
	logic                take;
	logic [1:0]          push_n;

	assign adv       = valid_s1 && room;
	assign src_stall = valid_s1 && !room;
	assign take      = src_valid && !src_stall;
	assign push_n    = adv ? res.n : 2'd0;

	// Hold the accepted byte for the lexer step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ch_s1  <= ch;
			eof_s1 <= end_of_input;
		end
	end

	// Lexer state advances with each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: slx_pkg::M_IDLE, first_chars: '0, run_len: 16'd0,
				accum: 32'd0, pos: 32'd0, start: 32'd0};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	slx_step u_step (
		.st  (state_q),
		.ch  (ch_s1),
		.eof (eof_s1),
		.nxt (state_nxt),
		.res (res)
	);

	slx_tokq u_tokq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_res  (res),
		.pop       (tok_valid && !tok_stall),
		.room      (room),
		.not_empty (tok_valid),
		.head_tok  (head_tok)
	);

	assign token_kind   = head_tok.kind;
	assign int_value    = head_tok.value;
	assign token_start  = head_tok.start;
	assign token_length = head_tok.len;
	assign bad_char     = head_tok.bad;
	assign last         = head_tok.last;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == slx_pkg::M_HALT |=> state_q.mode == slx_pkg::M_HALT)
		else $error("lexer left halt without reset");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == slx_pkg::M_HALT |-> push_n == 2'd0)
		else $error("halted lexer produced a token");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pos != $past(state_q.pos) |-> state_q.pos == $past(state_q.pos) + 32'd1)
		else $error("stream offset jumped");

endmodule

[test/source_text_lexer_tb.sv]
// ----------------------------------------------------------------------------
// source_text_lexer_tb - self-checking bench for the source text lexer
// Feeds byte items, some directed and most built from random lexemes, through
// a bursty source channel, and checks every token against a local lexer
// predictor while the token channel stalls on a changing pattern.
// ----------------------------------------------------------------------------
module source_text_lexer_tb;

	typedef struct packed {
		logic [7:0] ch;
		logic       eof;
	} byte_item_t;

	typedef enum logic [1:0] {
		PACE_FREE,
		PACE_COIN,
		PACE_EVERY4,
		PACE_HEAVY
	} pace_t;

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               src_valid    = 1'b0;
	logic               src_stall;
	logic [7:0]         ch           = 8'h00;
	logic               end_of_input = 1'b0;
	logic               tok_valid;
	logic               tok_stall    = 1'b0;
	logic [4:0]         token_kind;
	logic signed [31:0] int_value;
	logic [31:0]        token_start;
	logic [15:0]        token_length;
	logic [7:0]         bad_char;
	logic               last;

	byte_item_t      src_q[$];
	slx_pkg::token_t due_tokens[$];
	int              item_total = 0;
	int              taken_cnt  = 0;
	int              fail_cnt   = 0;
	int              burst_left = 1;
	int              gap_left   = 0;
	pace_t           pace       = PACE_FREE;
	int              pace_left  = 0;

	string keywords[4] = '{"fn", "ret", "var", "if"};

	// Lexer predictor state
	slx_pkg::lex_mode_t p_mode  = slx_pkg::M_IDLE;
	logic [7:0]  p_first[3] = '{8'h00, 8'h00, 8'h00};
	logic [15:0] p_len   = 16'd0;
	logic [31:0] p_acc   = 32'd0;
	logic [31:0] p_pos   = 32'd0;
	logic [31:0] p_start = 32'd0;

	source_text_lexer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.ch           (ch),
		.end_of_input (end_of_input),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.int_value    (int_value),
		.token_start  (token_start),
		.token_length (token_length),
		.bad_char     (bad_char),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Character classes
	function automatic logic is_letter(logic [7:0] c);
		return c inside {["a":"z"], ["A":"Z"]};
	endfunction

	function automatic logic is_num(logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return c inside {" ", [8'h09:8'h0D]};
	endfunction

	// Map a one-byte symbol to its kind; anything unknown is an error
	function automatic slx_pkg::token_kind_t sym_kind(logic [7:0] c);
		case (c)
			";":     return slx_pkg::KIND_SEMI;
			",":     return slx_pkg::KIND_COMMA;
			"{":     return slx_pkg::KIND_LBRACE;
			"}":     return slx_pkg::KIND_RBRACE;
			"(":     return slx_pkg::KIND_LPAREN;
			")":     return slx_pkg::KIND_RPAREN;
			":":     return slx_pkg::KIND_COLON;
			"*":     return slx_pkg::KIND_MUL;
			"/":     return slx_pkg::KIND_DIV;
			"+":     return slx_pkg::KIND_ADD;
			"-":     return slx_pkg::KIND_SUB;
			default: return slx_pkg::KIND_ERROR;
		endcase
	endfunction

	task automatic push_token(input slx_pkg::token_kind_t kind, input logic [31:0] val,
			input logic [31:0] start, input logic [15:0] len, input logic [7:0] bad);
		slx_pkg::token_t t;
		t.kind  = kind;
		t.value = val;
		t.start = start;
		t.len   = len;
		t.bad   = bad;
		t.last  = 1'b0;
		due_tokens.push_back(t);
	endtask

	// Lex a byte from the idle state
	task automatic start_lexeme(input logic [7:0] c, input logic eof);
		slx_pkg::token_kind_t k;
		p_mode = slx_pkg::M_IDLE;
		if (eof) begin
			push_token(slx_pkg::KIND_EOF, 32'd0, p_pos, 16'd0, 8'h00);
		end else if (is_blank(c)) begin
		end else if (is_letter(c)) begin
			p_mode     = slx_pkg::M_IDENT;
			p_first    = '{c, 8'h00, 8'h00};
			p_len      = 16'd1;
			p_start    = p_pos;
		end else if (is_num(c)) begin
			p_mode  = slx_pkg::M_NUM;
			p_acc   = 32'(c - "0");
			p_len   = 16'd1;
			p_start = p_pos;
		end else if (c == "#") begin
			p_mode = slx_pkg::M_COMMENT;
		end else if (c == "=") begin
			p_mode  = slx_pkg::M_EQ;
			p_start = p_pos;
		end else begin
			k = sym_kind(c);
			if (k == slx_pkg::KIND_ERROR) begin
				push_token(slx_pkg::KIND_ERROR, 32'd0, p_pos, 16'd1, c);
				p_mode = slx_pkg::M_HALT;
			end else begin
				push_token(k, 32'd0, p_pos, 16'd1, 8'h00);
			end
		end
	endtask

	// Advance the predictor by one accepted item and queue its tokens
	task automatic lex_byte(input logic [7:0] c, input logic eof);
		int                   n_before;
		slx_pkg::token_kind_t k;
		n_before = due_tokens.size();
		if (p_mode == slx_pkg::M_HALT)
			return;
		case (p_mode)
			slx_pkg::M_IDENT: begin
				if (!eof && (is_letter(c) || is_num(c))) begin
					if (p_len < 16'd3)
						p_first[p_len[1:0]] = c;
					if (p_len != 16'hFFFF)
						p_len++;
				end else begin
					// close the word, keywords by first characters and length
					k = slx_pkg::KIND_IDENT;
					if (p_len == 16'd2 && p_first[0] == "f" && p_first[1] == "n")
						k = slx_pkg::KIND_FN;
					else if (p_len == 16'd2 && p_first[0] == "i" && p_first[1] == "f")
						k = slx_pkg::KIND_IF;
					else if (p_len == 16'd3 && p_first[0] == "r" && p_first[1] == "e"
							&& p_first[2] == "t")
						k = slx_pkg::KIND_RET;
					else if (p_len == 16'd3 && p_first[0] == "v" && p_first[1] == "a"
							&& p_first[2] == "r")
						k = slx_pkg::KIND_VAR;
					push_token(k, 32'd0, p_start, p_len, 8'h00);
					start_lexeme(c, eof);
				end
			end
			slx_pkg::M_NUM: begin
				if (!eof && is_num(c)) begin
					p_acc = p_acc * 32'd10 + 32'(c - "0");
					if (p_len != 16'hFFFF)
						p_len++;
				end else begin
					push_token(slx_pkg::KIND_INT, p_acc, p_start, p_len, 8'h00);
					start_lexeme(c, eof);
				end
			end
			slx_pkg::M_COMMENT: begin
				if (eof)
					start_lexeme(c, eof);
				else if (c == "\n" || c == "\r")
					p_mode = slx_pkg::M_IDLE;
			end
			slx_pkg::M_EQ: begin
				if (!eof && c == "=") begin
					push_token(slx_pkg::KIND_EQUAL, 32'd0, p_start, 16'd2, 8'h00);
					p_mode = slx_pkg::M_IDLE;
				end else begin
					push_token(slx_pkg::KIND_ASSIGN, 32'd0, p_start, 16'd1, 8'h00);
					start_lexeme(c, eof);
				end
			end
			default: start_lexeme(c, eof);
		endcase
		if (!eof)
			p_pos++;
		if (due_tokens.size() > n_before)
			due_tokens[due_tokens.size() - 1].last = 1'b1;
	endtask

	// Stimulus helpers
	task automatic push_item(input logic [7:0] c, input logic eof);
		byte_item_t it;
		it.ch  = c;
		it.eof = eof;
		src_q.push_back(it);
	endtask

	task automatic push_byte(input logic [7:0] c);
		push_item(c, 1'b0);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
			: 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_alnum();
		return $urandom_range(0, 3) == 0 ? 8'("0" + $urandom_range(0, 9)) : rand_letter();
	endfunction

	// Append one random lexeme, separator or stray byte
	task automatic add_lexeme();
		int         pick;
		int         n;
		string      s;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			n = $urandom_range(0, 7);
			s = keywords[$urandom_range(0, 3)];
			if (n < 3) begin
				push_text(s);
			end else if (n == 3) begin
				push_text(s);
				push_byte(rand_alnum());
			end else if (n == 4) begin
				push_text(s.substr(0, s.len() - 2));
			end else begin
				push_byte(rand_letter());
				repeat ($urandom_range(0, 9))
					push_byte(rand_alnum());
			end
		end else if (pick < 35) begin
			repeat ($urandom_range(1, 12))
				push_byte(8'("0" + $urandom_range(0, 9)));
		end else if (pick < 55) begin
			s = ";,{}()*/+-:";
			push_byte(s[$urandom_range(0, s.len() - 1)]);
		end else if (pick < 65) begin
			push_byte("=");
			if ($urandom_range(0, 1))
				push_byte("=");
		end else if (pick < 80) begin
			s = " \t\n\v\f\r";
			repeat ($urandom_range(1, 3))
				push_byte(s[$urandom_range(0, s.len() - 1)]);
		end else if (pick < 88) begin
			// comment body takes any byte but a line end
			push_byte("#");
			repeat ($urandom_range(0, 8)) begin
				do
					b = 8'($urandom_range(0, 255));
				while (b == "\n" || b == "\r");
				push_byte(b);
			end
			n = $urandom_range(0, 4);
			if (n == 0)
				push_item(8'($urandom_range(0, 255)), 1'b1);
			else
				push_byte(n < 3 ? "\n" : "\r");
		end else if (pick < 92) begin
			push_item(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			// stray known byte
			do
				b = 8'($urandom_range(0, 127));
			while (!(is_letter(b) || is_num(b) || is_blank(b) || b == "#" || b == "="
					|| sym_kind(b) != slx_pkg::KIND_ERROR));
			push_byte(b);
		end
	endtask

	task automatic log_fail(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%s", msg);
	endtask

	// Source side: hand out queued items in bursts with gaps between
	always @(posedge clk) begin : drive_src
		byte_item_t it;
		if (arst_n) begin
			if (src_valid && !src_stall) begin
				lex_byte(ch, end_of_input);
				taken_cnt++;
			end
			if (!src_valid || !src_stall) begin
				if (gap_left > 0) begin
					src_valid <= 1'b0;
					gap_left--;
				end else if (src_q.size() == 0) begin
					src_valid <= 1'b0;
				end else begin
					it = src_q.pop_front();
					ch           <= it.ch;
					end_of_input <= it.eof;
					src_valid    <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 48);
						gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// Token side: stall on a randomly chosen pattern that changes during the run
	always @(posedge clk) begin : pace_tok
		if (pace_left == 0) begin
			pace      = pace_t'($urandom_range(0, 3));
			pace_left = $urandom_range(16, 160);
		end else begin
			pace_left--;
		end
		case (pace)
			PACE_FREE:   tok_stall <= 1'b0;
			PACE_COIN:   tok_stall <= ($urandom_range(0, 1) != 0);
			PACE_EVERY4: tok_stall <= (pace_left % 4) == 0;
			default:     tok_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// Compare each taken token with the oldest one due
	always @(posedge clk) begin : check_tok
		slx_pkg::token_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (due_tokens.size() == 0) begin
				log_fail($sformatf("unexpected token: kind %0d start %0d len %0d",
					token_kind, token_start, token_length));
			end else begin
				want = due_tokens.pop_front();
				if (token_kind !== want.kind || int_value !== want.value
						|| token_start !== want.start || token_length !== want.len
						|| bad_char !== want.bad || last !== want.last)
					log_fail($sformatf({"token mismatch (expected/actual): kind %0d/%0d ",
						"value %h/%h start %0d/%0d len %0d/%0d bad %h/%h last %b/%b"},
						want.kind, token_kind, want.value, int_value, want.start,
						token_start, want.len, token_length, want.bad, bad_char,
						want.last, last));
			end
		end
	end

	initial begin
		// directed: keywords, both equal forms, comment with a high byte,
		// a wrapping literal pending at end of input, bytes after eof
		push_text("fn ret=var==if#");
		push_byte(8'hFF);
		push_byte("\n");
		push_text("4294967297");
		push_item(8'hFF, 1'b1);
		push_byte("z");
		push_item(8'h00, 1'b1);

		// random lexemes
		while (src_q.size() < 1940)
			add_lexeme();

		// close any pending token, then end the stream
		push_byte(";");
		push_item(8'($urandom_range(0, 255)), 1'b1);

		// unknown byte, then items the halted lexer must drop
		push_byte($urandom_range(0, 1) ? 8'h00 : 8'(128 + $urandom_range(0, 127)));
		push_text("a1;");
		push_item(8'h00, 1'b1);
		item_total = src_q.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (taken_cnt != item_total || due_tokens.size() != 0)
			@(negedge clk);
		repeat (16) @(posedge clk);
		if (fail_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

endmodule
